### rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam logic [7:0] STAR_BYTE = 8'd42;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] byte_value;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       text_step;
        logic       fresh;
        logic [7:0] byte_value;
    } t_cell_ctl;

endpackage

### rtl/wgm_cell.sv
module wgm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wgm_pkg::t_cell_ctl i_ctl,
    input  logic              i_first,
    input  logic              i_prev_used,
    input  logic              i_start_we,
    input  logic              i_start,
    input  logic              i_carry,
    output logic              o_used,
    output logic              o_carry,
    output logic              o_start_we,
    output logic              o_start,
    output logic              o_end_active,
    output logic              o_end_start
);

    logic [7:0] r_byte;
    logic       r_used;
    logic       r_start;
    logic       r_act;

    logic act_eff;
    logic is_star;
    logic closed;
    logic is_end;

    assign act_eff = i_ctl.fresh ? r_start : r_act;
    assign is_star = (r_byte == wgm_pkg::STAR_BYTE);
    assign closed  = (act_eff & r_used & is_star) | i_carry;
    assign o_carry = r_used & ((act_eff & !is_star & (r_byte == i_ctl.byte_value))
                             | (closed & is_star));
    assign is_end  = !r_used & i_prev_used;

    assign o_used       = r_used;
    assign o_start_we   = i_ctl.append & is_end;
    assign o_start      = r_start & (i_ctl.byte_value == wgm_pkg::STAR_BYTE);
    assign o_end_active = closed & is_end;
    assign o_end_start  = r_start & is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_start <= i_first;
        end else if (i_ctl.clear) begin
            r_used  <= 1'b0;
            r_start <= i_first;
        end else begin
            if (i_ctl.append && is_end) begin
                r_used <= 1'b1;
            end
            if (i_start_we) begin
                r_start <= i_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && is_end) begin
            r_byte <= i_ctl.byte_value;
        end
        if (i_ctl.text_step) begin
            r_act <= closed;
        end
    end

endmodule

### rtl/wildcard_glob_matcher_top.sv
// Star-only wildcard matcher. Load a pattern with one clear transfer followed by one
// append transfer per byte (byte 42 is the star, which matches any run of text bytes,
// including none); bytes beyond the capacity of 32 are dropped and raise the sticky
// overflow flag. Then stream text one byte per transfer and set last on the final
// byte; a query transfer asks about the empty text. Each text-last or query transfer
// yields one result carrying the match bit and the overflow flag. The block takes
// one transfer every clock cycle: each pattern position is a cell, and the reachable
// set advances combinationally through a ripple from cell to cell along the chain of
// 32 cells. The input stalls only when the output register and its skid slot both
// hold untaken results.
module wildcard_glob_matcher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wgm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wgm_pkg::t_out_item  o_out_data
);

    localparam int N = wgm_pkg::PATTERN_MAX;

    wgm_pkg::t_cell_ctl ctl;
    logic               in_fire;
    logic               r_fresh;
    logic               r_ovf;
    logic               r_start_last;

    logic [N:0]   carry;
    logic [N-1:0] used_chain;
    logic [N:0]   start_we;
    logic [N:0]   start_val;
    logic [N-1:0] used;
    logic [N-1:0] end_active;
    logic [N-1:0] end_start;

    logic               res_valid;
    wgm_pkg::t_out_item res;
    logic               r_out_valid;
    wgm_pkg::t_out_item r_out;
    logic               r_skid_valid;
    wgm_pkg::t_out_item r_skid;
    logic               out_free;

    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid & !o_in_stall;

    assign ctl.clear      = in_fire & (i_in_data.action == wgm_pkg::ACT_CLEAR);
    assign ctl.append     = in_fire & (i_in_data.action == wgm_pkg::ACT_APPEND);
    assign ctl.text_step  = in_fire & (i_in_data.action == wgm_pkg::ACT_TEXT)
                          & !i_in_data.last;
    assign ctl.fresh      = r_fresh;
    assign ctl.byte_value = i_in_data.byte_value;

    assign carry[0]      = 1'b0;
    assign used_chain    = {used[N-2:0], 1'b1};
    assign start_we[0]   = 1'b0;
    assign start_val[0]  = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        wgm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_first      (g == 0),
            .i_prev_used  (used_chain[g]),
            .i_start_we   (start_we[g]),
            .i_start      (start_val[g]),
            .i_carry      (carry[g]),
            .o_used       (used[g]),
            .o_carry      (carry[g+1]),
            .o_start_we   (start_we[g+1]),
            .o_start      (start_val[g+1]),
            .o_end_active (end_active[g]),
            .o_end_start  (end_start[g])
        );
    end

    always_comb begin
        res_valid            = 1'b0;
        res.pattern_overflow = r_ovf;
        res.matched          = 1'b0;
        if (in_fire) begin
            case (i_in_data.action)
                wgm_pkg::ACT_TEXT: begin
                    res_valid   = i_in_data.last;
                    res.matched = (|end_active) | (carry[N] & used[N-1]);
                end
                wgm_pkg::ACT_QUERY: begin
                    res_valid   = 1'b1;
                    res.matched = (|end_start) | (r_start_last & used[N-1]);
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
            r_ovf   <= 1'b0;
        end else if (in_fire) begin
            r_fresh <= !ctl.text_step;
            if (ctl.clear) begin
                r_ovf <= 1'b0;
            end else if (ctl.append && used[N-1]) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_we[N]) begin
            r_start_last <= start_val[N];
        end
    end

    assign out_free = !r_out_valid | !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_valid;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while the output register is empty");

    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((used + 1'b1) & used) == '0)
        else $error("stored pattern positions are not a contiguous prefix");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clear |=> (used == '0))
        else $error("pattern not empty after a clear transfer");

    a_overflow_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.append && used[N-1]) |=> r_ovf)
        else $error("append to a full pattern did not raise overflow");

endmodule
